// ----- design/icrc_pkg.sv -----
// Shared types, constants and CRC helpers for the RoCEv2 invariant CRC engine.
// Used by rocev2_icrc_engine_core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package icrc_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
    localparam logic [15:0] ET_IPV4   = 16'h0800;
    localparam logic [15:0] ET_IPV6   = 16'h86DD;
    localparam logic [15:0] ET_QTAG   = 16'h8100;
    localparam logic [15:0] ET_ADTAG  = 16'h88A8;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [14:0] ETH_LEN   = 15'd14;
    localparam logic [14:0] POS_MAX   = 15'h7FFF;
    localparam logic [3:0]  IP_V4     = 4'd4;
    localparam logic [3:0]  IP_V6     = 4'd6;

    // Operation register codes
    localparam logic [1:0] OP_FULL   = 2'd0;
    localparam logic [1:0] OP_TRIM   = 2'd1;
    localparam logic [1:0] OP_VERIFY = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MISMATCH  = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    typedef enum logic [1:0] {
        PH_ETH,
        PH_TAG,
        PH_IP,
        PH_BAD
    } phase_t;

    // One frame end in flight through the tail pipeline
    typedef struct packed {
        logic [31:0]     crc;
        logic [3:0][7:0] hold;
        logic [3:0]      en;
        logic [3:0][7:0] mb;
        logic            ok;
        logic            verify;
    } tail_t;

    // Reflected CRC32 update by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Register value after the all-ones seed and eight 0xFF bytes
    function automatic logic [31:0] crc_seed();
        logic [31:0] c;
        c = ALL_ONES;
        for (int k = 0; k < 8; k++) begin
            c = crc_byte(c, 8'hFF);
        end
        return c;
    endfunction

    localparam logic [31:0] CRC_SEED = crc_seed();

    // Replace variant header fields by ones
    function automatic logic [7:0] mask_byte(input logic [14:0] rel, input logic [3:0] ver,
                                             input logic [5:0] hdr, input logic [7:0] b);
        logic [14:0] h;
        logic [7:0]  r;
        h = {9'd0, hdr};
        r = b;
        if (ver == IP_V4) begin
            if (rel == 15'd1 || rel == 15'd8 || rel == 15'd10 || rel == 15'd11 ||
                rel == h + 15'd6 || rel == h + 15'd7 || rel == h + 15'd12) begin
                r = 8'hFF;
            end
        end else if (ver == IP_V6) begin
            if (rel == 15'd0) begin
                r = {b[7:4], 4'hF};
            end else if (rel == 15'd1 || rel == 15'd2 || rel == 15'd3 || rel == 15'd7 ||
                         rel == 15'd46 || rel == 15'd47 || rel == 15'd52) begin
                r = 8'hFF;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/rocev2_icrc_engine_core.sv -----
// RoCEv2 invariant CRC engine top level: byte parser, CRC datapath, tail pipeline.
// Depends on icrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input channel (in_valid/in_ready) carries one frame byte per transfer, with
//   last marking the final byte. One byte is taken every cycle while in_ready is high;
//   the CRC register is updated once per byte, four bytes behind the input through a holdback line.
//   Output channel (out_valid/out_ready) carries one transfer per frame: icrc and
//   status. After the last byte the frame passes tail stages zero to three, then the
//   result register; the four trailing bytes are captured by the tail pipeline, and
//   tail stages one to three and the result register each fold one of them in.
//   Throughput: one byte per cycle while in_ready is high, frames back to back, including one-byte frames.
//   A stalled receiver first fills the result register and the tail stages; in_ready
//   drops once all of them are occupied.
//   The APB port holds the operation register (address 0); write it only while idle.
//   Reset clears the operation to full-frame mode and returns the parser to the
//   start of a frame; no clearing pass is needed.
module rocev2_icrc_engine_core #(
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      icrc,
    output logic [1:0]       status,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [14:0] MAX_POS = 15'(MAX_FRAME_BYTES);

    // Configuration register
    logic [1:0] op_reg;

    // Frame state
    logic [31:0]       crc_reg, crc_next;
    logic [14:0]       pos_reg, pos_next;
    icrc_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]       ts_reg, ts_next;
    logic [14:0]       off_reg, off_next;
    logic [3:0]        ver_reg, ver_next;
    logic [5:0]        hdr_reg, hdr_next;
    logic [3:0][7:0]   hold_reg, hold_next;
    logic              ferr_reg, ferr_next;
    logic              udp_reg, udp_next;

    // Tail pipeline and result
    icrc_pkg::tail_t   st_reg [4];
    icrc_pkg::tail_t   stage_in [4];
    logic [3:0]        vld_reg;
    logic [4:0]        free;
    icrc_pkg::tail_t   tail_in;
    logic              out_valid_reg;
    logic [31:0]       icrc_reg;
    logic [1:0]        status_reg;

    logic              in_xfer;
    logic              ferr_now;
    logic [14:0]       feed_pos;
    logic [15:0]       total, len;
    logic              trim, len_ok, hdr_ok;
    logic [15:0]       off16;
    logic [14:0]       tpos [4];

    // APB port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {30'd0, op_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= icrc_pkg::OP_FULL;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            op_reg <= pwdata[1:0];
        end
    end

    // Elastic tail pipeline flow control
    always_comb
    begin
        free[4] = !out_valid_reg || out_ready;
        for (int i = 3; i >= 0; i--) begin
            free[i] = !vld_reg[i] || free[i + 1];
        end
    end
    assign in_ready = free[0];
    assign in_xfer  = in_valid && in_ready;

    // Byte datapath: CRC feed from the holdback line, then header parse
    always_comb
    begin
        ferr_now   = ferr_reg || (pos_reg >= MAX_POS);
        feed_pos   = pos_reg - 15'd4;
        crc_next   = crc_reg;
        if (pos_reg >= 15'd4 && !ferr_now && phase_reg == icrc_pkg::PH_IP &&
            feed_pos >= off_reg)
        begin
            crc_next = icrc_pkg::crc_byte(crc_reg,
                icrc_pkg::mask_byte(feed_pos - off_reg, ver_reg, hdr_reg, hold_reg[0]));
        end
        hold_next  = {data_byte, hold_reg[3], hold_reg[2], hold_reg[1]};
        phase_next = phase_reg;
        ts_next    = ts_reg;
        off_next   = off_reg;
        ver_next   = ver_reg;
        hdr_next   = hdr_reg;
        udp_next   = udp_reg;
        ferr_next  = ferr_now;
        if (!ferr_now)
        begin
            if (phase_reg == icrc_pkg::PH_ETH || phase_reg == icrc_pkg::PH_TAG)
            begin
                ts_next = {ts_reg[7:0], data_byte};
                if ((phase_reg == icrc_pkg::PH_ETH && pos_reg == icrc_pkg::ETH_LEN - 15'd1) ||
                    (phase_reg == icrc_pkg::PH_TAG && pos_reg == off_reg + 15'd3))
                begin
                    if (ts_next == icrc_pkg::ET_QTAG || ts_next == icrc_pkg::ET_ADTAG)
                    begin
                        phase_next = icrc_pkg::PH_TAG;
                        off_next   = (phase_reg == icrc_pkg::PH_ETH) ? icrc_pkg::ETH_LEN
                                                                     : off_reg + 15'd4;
                    end
                    else if (ts_next == icrc_pkg::ET_IPV4 || ts_next == icrc_pkg::ET_IPV6)
                    begin
                        phase_next = icrc_pkg::PH_IP;
                        off_next   = (phase_reg == icrc_pkg::PH_ETH) ? icrc_pkg::ETH_LEN
                                                                     : off_reg + 15'd4;
                    end
                    else
                    begin
                        phase_next = icrc_pkg::PH_BAD;
                    end
                end
            end
            else if (phase_reg == icrc_pkg::PH_IP && pos_reg >= off_reg)
            begin
                if (pos_reg == off_reg)
                begin
                    ver_next = data_byte[7:4];
                    if (data_byte[7:4] == icrc_pkg::IP_V4)
                    begin
                        hdr_next = {data_byte[3:0], 2'b00};
                    end
                    else if (data_byte[7:4] == icrc_pkg::IP_V6)
                    begin
                        hdr_next = 6'd40;
                    end
                end
                else if ((ver_reg == icrc_pkg::IP_V4 && pos_reg - off_reg == 15'd9) ||
                         (ver_reg == icrc_pkg::IP_V6 && pos_reg - off_reg == 15'd6))
                begin
                    udp_next = (data_byte == icrc_pkg::PROTO_UDP);
                end
            end
        end
        pos_next = (pos_reg < icrc_pkg::POS_MAX) ? pos_reg + 15'd1 : icrc_pkg::POS_MAX;
    end

    // Frame end: length checks and the trailing bytes still to fold in
    always_comb
    begin
        total  = {1'b0, pos_reg} + 16'd1;
        trim   = (op_reg == icrc_pkg::OP_TRIM) || (op_reg == icrc_pkg::OP_VERIFY);
        len_ok = !trim || (total > 16'd4);
        len    = !trim ? total : ((total > 16'd4) ? total - 16'd4 : 16'd0);
        off16  = {1'b0, off_next};
        if (ver_next == icrc_pkg::IP_V4)
        begin
            hdr_ok = (hdr_next >= 6'd20) && (off16 + {10'd0, hdr_next} + 16'd20 <= len);
        end
        else if (ver_next == icrc_pkg::IP_V6)
        begin
            hdr_ok = (off16 + 16'd60 <= len);
        end
        else
        begin
            hdr_ok = 1'b0;
        end
        tail_in.crc    = crc_next;
        tail_in.hold   = hold_next;
        tail_in.ok     = len_ok && !ferr_now && phase_next == icrc_pkg::PH_IP &&
                         off16 < len && udp_next && hdr_ok;
        tail_in.verify = (op_reg == icrc_pkg::OP_VERIFY);
        for (int j = 0; j < 4; j++) begin
            tpos[j]       = pos_reg + 15'(j) - 15'd3;
            tail_in.en[j] = !trim && ({1'b0, pos_reg} + 16'(j) >= 16'd3) && !ferr_now &&
                            phase_next == icrc_pkg::PH_IP && tpos[j] >= off_next;
            tail_in.mb[j] = icrc_pkg::mask_byte(tpos[j] - off_next, ver_next, hdr_next,
                                                hold_next[j]);
        end
    end

    // Frame state registers: advance on each input transfer, clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= icrc_pkg::CRC_SEED;
            pos_reg   <= 15'd0;
            phase_reg <= icrc_pkg::PH_ETH;
            ts_reg    <= 16'd0;
            off_reg   <= 15'd0;
            ver_reg   <= 4'd0;
            hdr_reg   <= 6'd0;
            ferr_reg  <= 1'b0;
            udp_reg   <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (last)
            begin
                crc_reg   <= icrc_pkg::CRC_SEED;
                pos_reg   <= 15'd0;
                phase_reg <= icrc_pkg::PH_ETH;
                ts_reg    <= 16'd0;
                off_reg   <= 15'd0;
                ver_reg   <= 4'd0;
                hdr_reg   <= 6'd0;
                ferr_reg  <= 1'b0;
                udp_reg   <= 1'b0;
            end
            else
            begin
                crc_reg   <= crc_next;
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                ts_reg    <= ts_next;
                off_reg   <= off_next;
                ver_reg   <= ver_next;
                hdr_reg   <= hdr_next;
                ferr_reg  <= ferr_next;
                udp_reg   <= udp_next;
            end
        end
    end

    // Holdback line
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            hold_reg <= hold_next;
        end
    end

    // Tail pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (free[0])
            begin
                vld_reg[0] <= in_xfer && last;
            end
            for (int i = 1; i < 4; i++) begin
                if (free[i])
                begin
                    vld_reg[i] <= vld_reg[i - 1];
                end
            end
            if (free[4])
            begin
                out_valid_reg <= vld_reg[3];
            end
        end
    end

    // Next stage contents: fold the trailing byte that belongs to each stage
    always_comb
    begin
        stage_in[0] = tail_in;
        for (int i = 1; i < 4; i++) begin
            stage_in[i]     = st_reg[i - 1];
            stage_in[i].crc = st_reg[i - 1].en[i - 1]
                              ? icrc_pkg::crc_byte(st_reg[i - 1].crc, st_reg[i - 1].mb[i - 1])
                              : st_reg[i - 1].crc;
        end
    end

    // Tail pipeline payload: advance each stage that has room
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++) begin
            if (free[i])
            begin
                st_reg[i] <= stage_in[i];
            end
        end
    end

    // Result register: last byte, final inversion and verify compare
    logic [31:0] fin_crc, res;
    logic [31:0] be_word, le_word;
    always_comb
    begin
        fin_crc = st_reg[3].en[3] ? icrc_pkg::crc_byte(st_reg[3].crc, st_reg[3].mb[3])
                                  : st_reg[3].crc;
        res     = fin_crc ^ icrc_pkg::ALL_ONES;
        be_word = {st_reg[3].hold[0], st_reg[3].hold[1], st_reg[3].hold[2], st_reg[3].hold[3]};
        le_word = {st_reg[3].hold[3], st_reg[3].hold[2], st_reg[3].hold[1], st_reg[3].hold[0]};
    end

    always_ff @(posedge clk)
    begin
        if (free[4])
        begin
            if (!st_reg[3].ok)
            begin
                icrc_reg   <= 32'd0;
                status_reg <= icrc_pkg::ST_MALFORMED;
            end
            else
            begin
                icrc_reg   <= res;
                status_reg <= (st_reg[3].verify && res != be_word && res != le_word)
                              ? icrc_pkg::ST_MISMATCH : icrc_pkg::ST_OK;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign icrc      = icrc_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_rocev2_icrc_engine_core.sv -----
// Self-checking testbench for rocev2_icrc_engine_core: byte frames in, one CRC result per frame.
// Predicts icrc/status per transfer with its own frame parser; depends on icrc_pkg and the core.
`timescale 1ns / 1ps

module tb_rocev2_icrc_engine_core;

    localparam int MAX_BYTES  = 16384;
    localparam int STALL_MAX  = 5000;
    localparam int DRAIN_WAIT = 12;

    typedef struct packed {
        logic [31:0]       crc;
        int unsigned       pos;
        icrc_pkg::phase_t  ph;
        logic [15:0]       ety;
        int unsigned       ipoff;
        logic [3:0]        ver;
        int unsigned       hdr;
        logic [3:0][7:0]   hold;
        bit                err;
        bit                udp;
    } frame_state_t;

    typedef struct packed {
        logic [31:0] icrc;
        logic [1:0]  st;
    } crc_result_t;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  dbyte;
        bit          lst;
        bit          typed;
        logic [31:0] icrc;
        logic [1:0]  st;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] icrc;
    logic [1:0]  status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // typed expectation travelling with the current byte
    bit          row_typed = 1'b0;
    logic [31:0] row_icrc = 32'd0;
    logic [1:0]  row_st = icrc_pkg::ST_OK;

    logic [1:0]   op_reg = icrc_pkg::OP_FULL;
    frame_state_t frame_st;
    crc_result_t  pending_q[$];
    logic [7:0]   frame_q[$];
    int           snd_idle = 0;
    int           rcv_idle = 0;
    int           stall_cnt = 0;
    bit           failed = 1'b0;

    rocev2_icrc_engine_core #(.MAX_FRAME_BYTES(MAX_BYTES)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte), .last(last),
        .out_valid(out_valid), .out_ready(out_ready), .icrc(icrc), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 clk = ~clk;

    // ---------------- predictor ----------------

    // bitwise reflected CRC32 step, one data bit at a time
    function automatic logic [31:0] crc_advance(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r = r >> 1;
            if (fb) r = r ^ icrc_pkg::CRC_POLY;
        end
        return r;
    endfunction

    function automatic frame_state_t fresh_frame();
        frame_state_t s;
        s = '0;
        s.ph = icrc_pkg::PH_ETH;
        s.crc = icrc_pkg::ALL_ONES;
        for (int i = 0; i < 8; i++) s.crc = crc_advance(s.crc, 8'hFF);
        return s;
    endfunction

    // read variant header fields as ones
    function automatic logic [7:0] invariant_byte(frame_state_t s, int unsigned p, logic [7:0] b);
        int unsigned rel;
        rel = p - s.ipoff;
        if (s.ver == icrc_pkg::IP_V4) begin
            if (rel == 1 || rel == 8 || rel == 10 || rel == 11 ||
                rel == s.hdr + 6 || rel == s.hdr + 7 || rel == s.hdr + 12)
                return 8'hFF;
        end else if (s.ver == icrc_pkg::IP_V6) begin
            if (rel == 0) return {b[7:4], 4'hF};
            if (rel == 1 || rel == 2 || rel == 3 || rel == 7 ||
                rel == 46 || rel == 47 || rel == 52)
                return 8'hFF;
        end
        return b;
    endfunction

    function automatic void fold_byte(inout frame_state_t s, input int unsigned p,
                                      input logic [7:0] b);
        if (!s.err && s.ph == icrc_pkg::PH_IP && p >= s.ipoff)
            s.crc = crc_advance(s.crc, invariant_byte(s, p, b));
    endfunction

    function automatic void classify_type(inout frame_state_t s, input int unsigned off);
        if (s.ety == icrc_pkg::ET_QTAG || s.ety == icrc_pkg::ET_ADTAG) begin
            s.ph = icrc_pkg::PH_TAG;
            s.ipoff = off;
        end else if (s.ety == icrc_pkg::ET_IPV4 || s.ety == icrc_pkg::ET_IPV6) begin
            s.ph = icrc_pkg::PH_IP;
            s.ipoff = off;
        end else begin
            s.ph = icrc_pkg::PH_BAD;
        end
    endfunction

    function automatic void parse_header(inout frame_state_t s, input int unsigned pos,
                                         input logic [7:0] b);
        int unsigned rel;
        if (s.ph == icrc_pkg::PH_ETH || s.ph == icrc_pkg::PH_TAG) s.ety = {s.ety[7:0], b};
        if (s.ph == icrc_pkg::PH_ETH) begin
            if (pos == icrc_pkg::ETH_LEN - 1) classify_type(s, 32'(icrc_pkg::ETH_LEN));
        end else if (s.ph == icrc_pkg::PH_TAG) begin
            if (pos == s.ipoff + 3) classify_type(s, s.ipoff + 4);
        end else if (s.ph == icrc_pkg::PH_IP && pos >= s.ipoff) begin
            rel = pos - s.ipoff;
            if (rel == 0) begin
                s.ver = b[7:4];
                if (s.ver == icrc_pkg::IP_V4) s.hdr = 32'(b[3:0]) * 4;
                else if (s.ver == icrc_pkg::IP_V6) s.hdr = 40;
            end else if ((s.ver == icrc_pkg::IP_V4 && rel == 9) ||
                         (s.ver == icrc_pkg::IP_V6 && rel == 6)) begin
                s.udp = (b == icrc_pkg::PROTO_UDP);
            end
        end
    endfunction

    function automatic bit headers_covered(frame_state_t s, int unsigned len);
        if (s.err || s.ph != icrc_pkg::PH_IP || s.ipoff >= len || !s.udp) return 1'b0;
        if (s.ver == icrc_pkg::IP_V4) return s.hdr >= 20 && s.ipoff + s.hdr + 20 <= len;
        if (s.ver == icrc_pkg::IP_V6) return s.ipoff + 60 <= len;
        return 1'b0;
    endfunction

    // advance one byte; returns 1 with the frame result on a last byte
    function automatic bit icrc_step(inout frame_state_t s, input logic [1:0] op,
                                     input logic [7:0] b, input bit lst,
                                     output crc_result_t r);
        int unsigned pos, total, len, n;
        bit          ok;
        logic [31:0] v, be, le;
        pos = s.pos;
        r.icrc = 32'd0;
        r.st = icrc_pkg::ST_MALFORMED;
        if (pos >= MAX_BYTES) s.err = 1'b1;
        if (pos >= 4) fold_byte(s, pos - 4, s.hold[0]);
        s.hold = {b, s.hold[3:1]};
        if (!s.err) parse_header(s, pos, b);
        s.pos = (pos < icrc_pkg::POS_MAX) ? pos + 1 : 32'(icrc_pkg::POS_MAX);
        if (!lst) return 1'b0;
        total = pos + 1;
        n = (total < 4) ? total : 4;
        if (op == icrc_pkg::OP_TRIM || op == icrc_pkg::OP_VERIFY) begin
            ok = total > 4;
            len = ok ? total - 4 : 0;
        end else begin
            for (int k = 0; k < n; k++) fold_byte(s, total - n + k, s.hold[4 - n + k]);
            len = total;
            ok = 1'b1;
        end
        if (ok && headers_covered(s, len)) begin
            v = ~s.crc;
            r.icrc = v;
            r.st = icrc_pkg::ST_OK;
            if (op == icrc_pkg::OP_VERIFY) begin
                be = {s.hold[0], s.hold[1], s.hold[2], s.hold[3]};
                le = {s.hold[3], s.hold[2], s.hold[1], s.hold[0]};
                r.st = (v == be || v == le) ? icrc_pkg::ST_OK : icrc_pkg::ST_MISMATCH;
            end
        end
        s = fresh_frame();
        return 1'b1;
    endfunction

    // ---------------- monitors ----------------

    // predict on every input transfer
    always @(posedge clk) begin
        crc_result_t r;
        if (in_valid && in_ready) begin
            if (icrc_step(frame_st, op_reg, data_byte, last, r)) begin
                if (row_typed) begin
                    r.icrc = row_icrc;
                    r.st = row_st;
                end
                pending_q.push_back(r);
            end
        end
    end

    // compare every output transfer against the oldest prediction
    always @(posedge clk) begin
        crc_result_t e;
        if (out_valid && out_ready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result icrc=%h status=%0d", icrc, status);
                failed = 1'b1;
            end else begin
                e = pending_q.pop_front();
                if (icrc !== e.icrc) begin
                    $error("icrc: expected %h, actual %h", e.icrc, icrc);
                    failed = 1'b1;
                end
                if (status !== e.st) begin
                    $error("status: expected %0d, actual %0d", e.st, status);
                    failed = 1'b1;
                end
            end
        end
    end

    // random receiver stalls
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_MAX) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_byte(logic [7:0] b, bit lst, bit typed, logic [31:0] ei, logic [1:0] es);
        bit rdy;
        if ($urandom_range(0, 99) < snd_idle) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < snd_idle);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= lst;
        row_typed <= typed;
        row_icrc  <= ei;
        row_st    <= es;
        do begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end while (!rdy);
    endtask

    // hold off until every result is back and the tail pipeline is empty
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_operation(logic [1:0] op);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {30'd0, op};
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        op_reg  = op;
        @(posedge clk);
    endtask

    // build one frame in frame_q: mostly well formed, some noise and truncation
    task automatic build_frame(logic [1:0] op);
        int           kind, ntag, ihl, nhdr, cut;
        logic [15:0]  et;
        logic [7:0]   b0;
        frame_state_t t;
        crc_result_t  r;
        frame_q.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat (12) frame_q.push_back(8'($urandom_range(0, 255)));
        ntag = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (ntag) begin
            et = $urandom_range(0, 1) ? icrc_pkg::ET_QTAG : icrc_pkg::ET_ADTAG;
            frame_q.push_back(et[15:8]);
            frame_q.push_back(et[7:0]);
            frame_q.push_back(8'($urandom_range(0, 255)));
            frame_q.push_back(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 15))
            0:       et = 16'($urandom_range(0, 65535));
            1, 2, 3, 4, 5, 6: et = icrc_pkg::ET_IPV6;
            default: et = icrc_pkg::ET_IPV4;
        endcase
        frame_q.push_back(et[15:8]);
        frame_q.push_back(et[7:0]);
        if (et == icrc_pkg::ET_IPV6) begin
            b0 = {icrc_pkg::IP_V6, 4'($urandom_range(0, 15))};
            nhdr = 40;
        end else begin
            ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
            b0 = {icrc_pkg::IP_V4, 4'(ihl)};
            nhdr = (ihl < 5) ? 20 : ihl * 4;
        end
        if ($urandom_range(0, 19) == 0) b0[7:4] = 4'($urandom_range(0, 15));
        for (int i = 0; i < nhdr; i++) begin
            if (i == 0) frame_q.push_back(b0);
            else if ((et == icrc_pkg::ET_IPV6 && i == 6) || (et != icrc_pkg::ET_IPV6 && i == 9))
                frame_q.push_back(($urandom_range(0, 9) == 0) ?
                                  8'($urandom_range(0, 255)) : icrc_pkg::PROTO_UDP);
            else frame_q.push_back(8'($urandom_range(0, 255)));
        end
        repeat (20 + $urandom_range(0, 16)) frame_q.push_back(8'($urandom_range(0, 255)));
        // verify mode: make the trailer match in either byte order most of the time
        if (op == icrc_pkg::OP_VERIFY && $urandom_range(0, 2) != 0) begin
            t = fresh_frame();
            foreach (frame_q[i]) void'(icrc_step(t, icrc_pkg::OP_TRIM, frame_q[i], 1'b0, r));
            for (int i = 0; i < 4; i++)
                void'(icrc_step(t, icrc_pkg::OP_TRIM, 8'd0, i == 3, r));
            if ($urandom_range(0, 1))
                for (int i = 3; i >= 0; i--) frame_q.push_back(r.icrc[8*i +: 8]);
            else
                for (int i = 0; i < 4; i++) frame_q.push_back(r.icrc[8*i +: 8]);
        end else begin
            repeat (4) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        if (kind == 1) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
    endtask

    task automatic random_frames(logic [1:0] op, int nbytes);
        int sent;
        sent = 0;
        while (sent < nbytes) begin
            build_frame(op);
            foreach (frame_q[i])
                send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, 32'd0, icrc_pkg::ST_OK);
            sent += frame_q.size();
        end
    endtask

    row_t dir_rows[$];
    int   idle_snd[3] = '{16, 64, 0};
    int   idle_rcv[3] = '{64, 16, 0};

    initial begin
        // short frames and mode boundaries with results read off directly
        dir_rows = '{
            '{icrc_pkg::OP_FULL,   8'h00, 1'b1, 1'b1, 32'd0, icrc_pkg::ST_MALFORMED},
            '{icrc_pkg::OP_FULL,   8'hFF, 1'b1, 1'b1, 32'd0, icrc_pkg::ST_MALFORMED},
            '{icrc_pkg::OP_FULL,   8'hAA, 1'b0, 1'b0, 32'd0, icrc_pkg::ST_OK},
            '{icrc_pkg::OP_FULL,   8'h55, 1'b0, 1'b0, 32'd0, icrc_pkg::ST_OK},
            '{icrc_pkg::OP_FULL,   8'hFF, 1'b1, 1'b1, 32'd0, icrc_pkg::ST_MALFORMED},
            '{icrc_pkg::OP_TRIM,   8'h00, 1'b1, 1'b1, 32'd0, icrc_pkg::ST_MALFORMED},
            '{icrc_pkg::OP_TRIM,   8'h12, 1'b0, 1'b0, 32'd0, icrc_pkg::ST_OK},
            '{icrc_pkg::OP_TRIM,   8'h34, 1'b0, 1'b0, 32'd0, icrc_pkg::ST_OK},
            '{icrc_pkg::OP_TRIM,   8'h56, 1'b0, 1'b0, 32'd0, icrc_pkg::ST_OK},
            '{icrc_pkg::OP_TRIM,   8'h78, 1'b1, 1'b1, 32'd0, icrc_pkg::ST_MALFORMED},
            '{icrc_pkg::OP_TRIM,   8'h08, 1'b0, 1'b0, 32'd0, icrc_pkg::ST_OK},
            '{icrc_pkg::OP_TRIM,   8'h00, 1'b0, 1'b0, 32'd0, icrc_pkg::ST_OK},
            '{icrc_pkg::OP_TRIM,   8'hFF, 1'b0, 1'b0, 32'd0, icrc_pkg::ST_OK},
            '{icrc_pkg::OP_TRIM,   8'hFF, 1'b0, 1'b0, 32'd0, icrc_pkg::ST_OK},
            '{icrc_pkg::OP_TRIM,   8'h00, 1'b1, 1'b1, 32'd0, icrc_pkg::ST_MALFORMED},
            '{icrc_pkg::OP_VERIFY, 8'hFF, 1'b1, 1'b1, 32'd0, icrc_pkg::ST_MALFORMED},
            '{2'd3,                8'h00, 1'b1, 1'b1, 32'd0, icrc_pkg::ST_MALFORMED}
        };
        frame_st = fresh_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (dir_rows[i]) begin
            if (dir_rows[i].op != op_reg) write_operation(dir_rows[i].op);
            send_byte(dir_rows[i].dbyte, dir_rows[i].lst, dir_rows[i].typed,
                      dir_rows[i].icrc, dir_rows[i].st);
        end

        // random part under each idling pattern and every operation code
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle = idle_snd[ph];
            rcv_idle = idle_rcv[ph];
            for (int op = 0; op < 4; op++) begin
                write_operation(2'(op));
                random_frames(2'(op), 90);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (!failed && pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
